[design/jsu_pkg.sv]
package jsu_pkg;

    // job queue between classifier and serializer
    localparam int QDepth = 4;
    localparam int QAw    = $clog2(QDepth);

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_LETTER = 3'd1,
        ST_TRUNCATED  = 3'd2,
        ST_BAD_HEX    = 3'd3,
        ST_RAW_RANGE  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        PH_TEXT = 3'b001,
        PH_ESC  = 3'b010,
        PH_HEX  = 3'b100
    } t_phase;

    // one job: up to three output words; n_extra is the word count minus one
    typedef struct packed {
        logic [1:0] n_extra;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        t_status    status;
        logic       last;
    } t_job;

    localparam logic [7:0] ChQuote     = 8'h22;
    localparam logic [7:0] ChBackslash = 8'h5C;
    localparam logic [7:0] ChSlash     = 8'h2F;
    localparam logic [7:0] ChB         = 8'h62;
    localparam logic [7:0] ChF         = 8'h66;
    localparam logic [7:0] ChN         = 8'h6E;
    localparam logic [7:0] ChR         = 8'h72;
    localparam logic [7:0] ChT         = 8'h74;
    localparam logic [7:0] ChU         = 8'h75;

    localparam logic MODE_UTF8 = 1'b0;

    // {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c inside {[8'h61:8'h66]}) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c inside {[8'h41:8'h46]}) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    function automatic t_job single_job(input logic [7:0] b, input logic last);
        t_job j;
        j.n_extra = 2'd0;
        j.b0      = b;
        j.b1      = '0;
        j.b2      = '0;
        j.status  = ST_OK;
        j.last    = last;
        return j;
    endfunction

    function automatic t_job error_job(input t_status st);
        t_job j;
        j        = single_job(8'h00, 1'b1);
        j.status = st;
        return j;
    endfunction

    // expansion of a complete \u code
    function automatic t_job code_job(input logic [15:0] code, input logic mode,
                                      input logic last);
        t_job j;
        j = single_job(code[7:0], last);
        if (code[15:7] == '0) begin
            if (code[7:0] == ChQuote) begin
                j.n_extra = 2'd1;
                j.b0      = ChBackslash;
                j.b1      = ChQuote;
            end
        end else if (mode != MODE_UTF8) begin
            if (code[15:8] != '0) begin
                j = error_job(ST_RAW_RANGE);
            end
        end else if (code[15:11] == '0) begin
            j.n_extra = 2'd1;
            j.b0      = {3'b110, code[10:6]};
            j.b1      = {2'b10, code[5:0]};
        end else begin
            j.n_extra = 2'd2;
            j.b0      = {4'b1110, code[15:12]};
            j.b1      = {2'b10, code[11:6]};
            j.b2      = {2'b10, code[5:0]};
        end
        return j;
    endfunction

endpackage

[design/json_string_unescaper_core.sv]
// path: jobs are written into the job queue, and their words leave through the output register
// throughput: one input byte per cycle; the serializer sends one word per cycle while the output is ready,
// so a utf-8 code of two or three words holds the input back once the 4-entry job queue fills
// reset: synchronous active-low i_rst_n clears escape state, drop flag, queue and
// output valid; the mode register returns to utf-8 conversion
module json_string_unescaper_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input words
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    // result words
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic [2:0]  o_status,
    output logic        o_out_last,
    // mode register
    input  logic        i_cfg_we,
    input  logic        i_cfg_data
);

    logic          accept;
    logic          push;
    jsu_pkg::t_job push_job;
    logic          q_full;
    logic          q_valid;
    jsu_pkg::t_job head_job;
    logic          pop;

    // input is taken whenever the job queue has room, independent of the output side
    assign o_in_ready = !q_full;
    assign accept     = i_in_valid && o_in_ready;

    // front: escape tracking, hex collection and building of at most one job per byte
    jsu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_push     (push),
        .o_job      (push_job)
    );

    // short queue so a stalled output does not stop byte intake at once
    jsu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    // back: sends the one to three words of each job through the output register
    jsu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_status    (o_status),
        .o_out_last  (o_out_last)
    );

endmodule

[design/jsu_front.sv]
module jsu_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_in_byte,
    input  logic            i_in_last,
    input  logic            i_cfg_we,
    input  logic            i_cfg_data,
    output logic            o_push,
    output jsu_pkg::t_job   o_job
);

    jsu_pkg::t_phase r_phase, n_phase;
    logic [1:0]      r_digits, n_digits;
    logic [11:0]     r_accum, n_accum;
    logic            r_dropping, n_dropping;
    logic            r_mode;
    logic [4:0]      hex;

    assign hex = jsu_pkg::hex_digit(i_in_byte);

    always_comb begin
        n_phase    = r_phase;
        n_digits   = r_digits;
        n_accum    = r_accum;
        n_dropping = r_dropping;
        o_push     = 1'b0;
        o_job      = jsu_pkg::single_job(i_in_byte, i_in_last);
        if (i_accept) begin
            if (r_dropping) begin
                if (i_in_last) begin
                    n_dropping = 1'b0;
                    n_phase    = jsu_pkg::PH_TEXT;
                    n_digits   = '0;
                    n_accum    = '0;
                end
            end else begin
                n_phase  = jsu_pkg::PH_TEXT;
                n_digits = '0;
                n_accum  = '0;
                case (r_phase)
                    jsu_pkg::PH_ESC: begin
                        o_push = 1'b1;
                        case (i_in_byte)
                            jsu_pkg::ChQuote, jsu_pkg::ChBackslash, jsu_pkg::ChSlash: ;
                            jsu_pkg::ChB: o_job.b0 = 8'h08;
                            jsu_pkg::ChF: o_job.b0 = 8'h0C;
                            jsu_pkg::ChN: o_job.b0 = 8'h0A;
                            jsu_pkg::ChR: o_job.b0 = 8'h0D;
                            jsu_pkg::ChT: o_job.b0 = 8'h09;
                            jsu_pkg::ChU: begin
                                if (i_in_last) begin
                                    o_job = jsu_pkg::error_job(jsu_pkg::ST_TRUNCATED);
                                end else begin
                                    o_push  = 1'b0;
                                    n_phase = jsu_pkg::PH_HEX;
                                end
                            end
                            default: o_job = jsu_pkg::error_job(jsu_pkg::ST_BAD_LETTER);
                        endcase
                    end
                    jsu_pkg::PH_HEX: begin
                        o_push = 1'b1;
                        if (!hex[4]) begin
                            o_job = jsu_pkg::error_job(jsu_pkg::ST_BAD_HEX);
                        end else if (r_digits != 2'd3) begin
                            if (i_in_last) begin
                                o_job = jsu_pkg::error_job(jsu_pkg::ST_TRUNCATED);
                            end else begin
                                o_push   = 1'b0;
                                n_phase  = jsu_pkg::PH_HEX;
                                n_digits = r_digits + 2'd1;
                                n_accum  = {r_accum[7:0], hex[3:0]};
                            end
                        end else begin
                            o_job = jsu_pkg::code_job({r_accum, hex[3:0]}, r_mode,
                                                      i_in_last);
                        end
                    end
                    default: begin
                        // normal text
                        o_push = 1'b1;
                        if (i_in_byte == jsu_pkg::ChBackslash) begin
                            if (i_in_last) begin
                                o_job = jsu_pkg::error_job(jsu_pkg::ST_TRUNCATED);
                            end else begin
                                o_push  = 1'b0;
                                n_phase = jsu_pkg::PH_ESC;
                            end
                        end
                    end
                endcase
                if (o_push && o_job.status != jsu_pkg::ST_OK) begin
                    n_dropping = !i_in_last;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= jsu_pkg::PH_TEXT;
            r_digits   <= '0;
            r_accum    <= '0;
            r_dropping <= 1'b0;
            r_mode     <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_digits   <= n_digits;
            r_accum    <= n_accum;
            r_dropping <= n_dropping;
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
        end
    end

endmodule

[design/jsu_queue.sv]
module jsu_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  jsu_pkg::t_job   i_job,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output jsu_pkg::t_job   o_job
);

    jsu_pkg::t_job            r_mem [jsu_pkg::QDepth];
    logic [jsu_pkg::QAw-1:0]  r_wr, r_rd;
    logic [jsu_pkg::QAw:0]    r_cnt;
    logic                     do_push, do_pop;

    assign o_full  = (r_cnt == (jsu_pkg::QAw + 1)'(jsu_pkg::QDepth));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

[design/jsu_back.sv]
module jsu_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  jsu_pkg::t_job   i_job,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic [2:0]      o_status,
    output logic            o_out_last
);

    logic [1:0]  r_idx;
    logic        r_valid;
    logic [7:0]  r_byte, n_byte;
    logic [2:0]  r_status;
    logic        r_last;
    logic        load, last_piece;

    assign load       = i_q_valid && (!r_valid || i_out_ready);
    assign last_piece = (r_idx == i_job.n_extra);
    assign o_pop      = load && last_piece;

    always_comb begin
        case (r_idx)
            2'd0:    n_byte = i_job.b0;
            2'd1:    n_byte = i_job.b1;
            default: n_byte = i_job.b2;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte   <= n_byte;
            r_status <= i_job.status;
            r_last   <= last_piece && i_job.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= last_piece ? 2'd0 : r_idx + 2'd1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_byte  = r_byte;
    assign o_status    = r_status;
    assign o_out_last  = r_last;

endmodule

[design/jsu_checker.sv]
module jsu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  o_out_byte,
    input logic [2:0]  o_status,
    input logic        o_out_last
);

    // nothing pending after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("output valid or input stalled after reset");

    // an error word is a zero byte that closes the string
    a_error_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != jsu_pkg::ST_OK |-> o_out_byte == 8'h00 && o_out_last)
        else $error("error word without zero byte or last");

    // input is held off only while a word waits at the output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with the output empty");

    // stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_byte)
            && $stable(o_status) && $stable(o_out_last))
        else $error("output word changed while stalled");

endmodule

bind json_string_unescaper_core jsu_checker u_jsu_checker (.*);

[bench/json_string_unescaper_core_test.sv]
`timescale 1ns / 1ps

module json_string_unescaper_core_test;

    localparam logic MODE_RAW   = 1'b1;
    localparam int   CycleLimit = 100000;
    localparam int   PhaseWords = 75;
    localparam int   DrainWait  = 4;      // output register sits behind the job queue
    localparam int   HoldCycles = 80;     // long sink stall that backs the job queue up

    localparam logic [7:0] Ch0    = 8'h30;
    localparam logic [7:0] Ch9    = 8'h39;
    localparam logic [7:0] ChLowA = 8'h61;
    localparam logic [7:0] ChLowF = 8'h66;
    localparam logic [7:0] ChUpA  = 8'h41;
    localparam logic [7:0] ChUpF  = 8'h46;

    // one result word
    typedef struct packed {
        logic [7:0]       b;
        jsu_pkg::t_status st;
        logic             last;
    } t_word;

    // one row of the directed script; typed rows carry their result word
    typedef struct packed {
        logic [7:0] b;
        logic       last;
        logic       typed;
        t_word      want;
    } t_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_in_byte;
    logic       i_in_last;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_out_byte;
    logic [2:0] o_status;
    logic       o_out_last;
    logic       i_cfg_we;
    logic       i_cfg_data;

    json_string_unescaper_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_status    (o_status),
        .o_out_last  (o_out_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    // words still owed by the block, oldest first
    t_word      owed[$];
    int         fails    = 0;
    int         words_in = 0;
    int         cycles   = 0;
    bit         calm     = 0;     // no idling on either side in the closing phase
    bit         held     = 0;     // long sink stall already done
    t_row       script[$];
    logic [7:0] draft[$];         // string being built by the random generator

    // unescaper state as the block should hold it
    logic            raw_mode    = jsu_pkg::MODE_UTF8;
    jsu_pkg::t_phase esc_phase   = jsu_pkg::PH_TEXT;
    logic [1:0]      digits_seen = '0;
    logic [15:0]     code_acc    = '0;
    logic            drop_rest   = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // unescape predictor
    // ---------------------------------------------------------------

    function automatic void owe(input logic [7:0] b, input jsu_pkg::t_status st,
                                input logic last);
        t_word w;
        w.b    = b;
        w.st   = st;
        w.last = last;
        owed.insert(owed.size(), w);
    endfunction

    function automatic void reset_escape();
        esc_phase   = jsu_pkg::PH_TEXT;
        digits_seen = '0;
        code_acc    = '0;
    endfunction

    // an error word ends the string; the rest of it is dropped unless this was its last byte
    function automatic void abort_string(input jsu_pkg::t_status st, input logic last);
        owe(8'h00, st, 1'b1);
        reset_escape();
        drop_rest = !last;
    endfunction

    function automatic void close_escape(input logic [7:0] b, input logic last);
        reset_escape();
        owe(b, jsu_pkg::ST_OK, last);
    endfunction

    function automatic int nibble_of(input logic [7:0] c);
        if (c >= Ch0 && c <= Ch9) return int'(c - Ch0);
        if (c >= ChLowA && c <= ChLowF) return int'(c - ChLowA) + 10;
        if (c >= ChUpA && c <= ChUpF) return int'(c - ChUpA) + 10;
        return -1;
    endfunction

    function automatic void emit_code(input logic [15:0] code, input logic last);
        if (code < 16'h0080) begin
            // a quote comes back escaped
            if (code[7:0] == jsu_pkg::ChQuote) begin
                owe(jsu_pkg::ChBackslash, jsu_pkg::ST_OK, 1'b0);
                owe(jsu_pkg::ChQuote, jsu_pkg::ST_OK, last);
            end else begin
                owe(code[7:0], jsu_pkg::ST_OK, last);
            end
        end else if (raw_mode == MODE_RAW) begin
            if (code > 16'h00FF) abort_string(jsu_pkg::ST_RAW_RANGE, last);
            else owe(code[7:0], jsu_pkg::ST_OK, last);
        end else if (code < 16'h0800) begin
            owe(8'hC0 | 8'(code >> 6), jsu_pkg::ST_OK, 1'b0);
            owe(8'h80 | 8'(code & 16'h003F), jsu_pkg::ST_OK, last);
        end else begin
            // surrogates are encoded one by one, never paired
            owe(8'hE0 | 8'(code >> 12), jsu_pkg::ST_OK, 1'b0);
            owe(8'h80 | 8'((code >> 6) & 16'h003F), jsu_pkg::ST_OK, 1'b0);
            owe(8'h80 | 8'(code & 16'h003F), jsu_pkg::ST_OK, last);
        end
    endfunction

    function automatic void unescape_byte(input logic [7:0] c, input logic last);
        int          d;
        logic [15:0] code;
        if (drop_rest) begin
            if (last) begin
                drop_rest = 1'b0;
                reset_escape();
            end
            return;
        end
        case (esc_phase)
            jsu_pkg::PH_ESC: begin
                case (c)
                    jsu_pkg::ChQuote, jsu_pkg::ChBackslash, jsu_pkg::ChSlash:
                        close_escape(c, last);
                    jsu_pkg::ChB: close_escape(8'h08, last);
                    jsu_pkg::ChF: close_escape(8'h0C, last);
                    jsu_pkg::ChN: close_escape(8'h0A, last);
                    jsu_pkg::ChR: close_escape(8'h0D, last);
                    jsu_pkg::ChT: close_escape(8'h09, last);
                    jsu_pkg::ChU: begin
                        if (last) begin
                            abort_string(jsu_pkg::ST_TRUNCATED, last);
                        end else begin
                            esc_phase   = jsu_pkg::PH_HEX;
                            digits_seen = '0;
                            code_acc    = '0;
                        end
                    end
                    default: abort_string(jsu_pkg::ST_BAD_LETTER, last);
                endcase
            end
            jsu_pkg::PH_HEX: begin
                d = nibble_of(c);
                if (d < 0) begin
                    abort_string(jsu_pkg::ST_BAD_HEX, last);
                end else begin
                    code = {code_acc[11:0], d[3:0]};
                    if (digits_seen < 2'd3) begin
                        if (last) begin
                            abort_string(jsu_pkg::ST_TRUNCATED, last);
                        end else begin
                            code_acc    = code;
                            digits_seen = digits_seen + 2'd1;
                        end
                    end else begin
                        reset_escape();
                        emit_code(code, last);
                    end
                end
            end
            default: begin
                esc_phase = jsu_pkg::PH_TEXT;
                if (c == jsu_pkg::ChBackslash) begin
                    if (last) abort_string(jsu_pkg::ST_TRUNCATED, last);
                    else esc_phase = jsu_pkg::PH_ESC;
                end else begin
                    owe(c, jsu_pkg::ST_OK, last);
                end
            end
        endcase
    endfunction

    // ---------------------------------------------------------------
    // input side
    // ---------------------------------------------------------------

    // offers one word, holds it until taken, then predicts from it
    task automatic send_word(input logic [7:0] b, input logic last, input logic typed,
                             input t_word want);
        int keep;
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_byte  = b;
        i_in_last  = last;
        do @(posedge i_clk); while (!o_in_ready);
        keep = owed.size();
        unescape_byte(b, last);
        // typed rows keep the predictor state moving but check their own word
        if (typed) begin
            while (owed.size() > keep) void'(owed.pop_back());
            owed.insert(owed.size(), want);
        end
        words_in++;
    endtask

    // mode changes only once the block has gone quiet
    task automatic set_mode(input logic m);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (owed.size() != 0) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = m;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        raw_mode   = m;
    endtask

    function automatic t_row free_row(input logic [7:0] b, input logic last);
        t_row r;
        r.b     = b;
        r.last  = last;
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic t_row fixed_row(input logic [7:0] b, input logic last,
                                       input logic [7:0] eb, input jsu_pkg::t_status est,
                                       input logic elast);
        t_row r;
        r.b         = b;
        r.last      = last;
        r.typed     = 1'b1;
        r.want.b    = eb;
        r.want.st   = est;
        r.want.last = elast;
        return r;
    endfunction

    function automatic void add_row(input t_row r);
        script.insert(script.size(), r);
    endfunction

    function automatic void add_char(input logic [7:0] c);
        draft.insert(draft.size(), c);
    endfunction

    function automatic logic [7:0] escape_key(input int k);
        case (k)
            0: return jsu_pkg::ChQuote;
            1: return jsu_pkg::ChBackslash;
            2: return jsu_pkg::ChSlash;
            3: return jsu_pkg::ChB;
            4: return jsu_pkg::ChF;
            5: return jsu_pkg::ChN;
            6: return jsu_pkg::ChR;
            default: return jsu_pkg::ChT;
        endcase
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return Ch0 + 8'(v);
        if ($urandom_range(0, 1) == 1) return ChUpA + 8'(v) - 8'd10;
        return ChLowA + 8'(v) - 8'd10;
    endfunction

    // code points spread over the one-, two- and three-byte ranges, boundaries now and then
    function automatic logic [15:0] pick_code();
        int cls;
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 6))
                0: return 16'h0000;
                1: return 16'h007F;
                2: return 16'h0080;
                3: return 16'h00FF;
                4: return 16'h07FF;
                5: return 16'h0800;
                default: return 16'hFFFF;
            endcase
        end
        // raw mode mostly stays in range so strings are not cut short
        if (raw_mode == MODE_RAW)
            cls = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 1) : $urandom_range(2, 3);
        else
            cls = $urandom_range(0, 3);
        case (cls)
            0: return ($urandom_range(0, 3) == 0) ? 16'(jsu_pkg::ChQuote)
                                                  : 16'($urandom_range(0, 127));
            1: return 16'($urandom_range(16'h0080, 16'h00FF));
            2: return 16'($urandom_range(16'h0100, 16'h07FF));
            default: return 16'($urandom_range(16'h0800, 16'hFFFF));
        endcase
    endfunction

    task automatic push_code(input logic [15:0] code);
        add_char(jsu_pkg::ChBackslash);
        add_char(jsu_pkg::ChU);
        for (int i = 3; i >= 0; i--) add_char(hex_char(code[i*4 +: 4]));
    endtask

    // builds one string body of mostly well-formed pieces and sends it
    task automatic send_string();
        int   pieces;
        int   pick;
        int   k;
        bit   cut;
        pieces = $urandom_range(1, 8);
        cut    = 0;
        draft.delete();
        for (int p = 0; p < pieces && !cut; p++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                k = $urandom_range(0, 254);
                add_char((k >= 8'h5C) ? 8'(k + 1) : 8'(k));
            end else if (pick < 55) begin
                add_char(jsu_pkg::ChBackslash);
                add_char(escape_key($urandom_range(0, 7)));
            end else if (pick < 85) begin
                push_code(pick_code());
            end else if (pick < 95) begin
                // broken escapes: odd letter, odd digit, or a string cut inside an escape
                add_char(jsu_pkg::ChBackslash);
                case ($urandom_range(0, 2))
                    0: add_char(8'($urandom_range(0, 255)));
                    1: begin
                        add_char(jsu_pkg::ChU);
                        repeat ($urandom_range(0, 3))
                            add_char(hex_char(4'($urandom_range(0, 15))));
                        add_char(8'($urandom_range(0, 255)));
                    end
                    default: begin
                        if ($urandom_range(0, 1) == 1) begin
                            add_char(jsu_pkg::ChU);
                            repeat ($urandom_range(0, 3))
                                add_char(hex_char(4'($urandom_range(0, 15))));
                        end
                        cut = 1;
                    end
                endcase
            end else begin
                add_char(8'($urandom_range(0, 255)));
            end
        end
        for (int i = 0; i < draft.size(); i++)
            send_word(draft[i], i == draft.size() - 1, 1'b0, '0);
    endtask

    task automatic random_phase(input logic m);
        int stop;
        set_mode(m);
        stop = words_in + PhaseWords;
        while (words_in < stop) send_string();
    endtask

    // ---------------------------------------------------------------
    // output side
    // ---------------------------------------------------------------

    // sink: random stalls, plus one long hold-off that backs the block up
    initial begin
        i_out_ready = 1'b0;
        do @(negedge i_clk); while (!i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && words_in >= 120) begin
                held        = 1;
                i_out_ready = 1'b0;
                repeat (HoldCycles) @(negedge i_clk);
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                i_out_ready = 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
        end
    end

    // result checker: every accepted word against the oldest owed one
    always @(posedge i_clk) begin
        t_word w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (owed.size() == 0) begin
                $display("%0t unexpected word: byte %h status %0d last %b",
                         $time, o_out_byte, o_status, o_out_last);
                fails++;
            end else begin
                w = owed.pop_front();
                if (o_out_byte !== w.b) begin
                    $display("%0t byte: expected %h, actual %h", $time, w.b, o_out_byte);
                    fails++;
                end
                if (o_status !== w.st) begin
                    $display("%0t status: expected %0d, actual %0d", $time, w.st, o_status);
                    fails++;
                end
                if (o_out_last !== w.last) begin
                    $display("%0t last: expected %b, actual %b", $time, w.last, o_out_last);
                    fails++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("json_string_unescaper_core: mismatch");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_byte  = '0;
        i_in_last  = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_data = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed script, utf-8 mode out of reset
        add_row(fixed_row(8'h00, 1'b0, 8'h00, jsu_pkg::ST_OK, 1'b0));
        add_row(fixed_row(8'hFF, 1'b0, 8'hFF, jsu_pkg::ST_OK, 1'b0));
        add_row(free_row(jsu_pkg::ChBackslash, 1'b0));
        add_row(free_row(jsu_pkg::ChQuote, 1'b0));
        add_row(free_row(jsu_pkg::ChBackslash, 1'b0));
        add_row(free_row(jsu_pkg::ChBackslash, 1'b0));
        add_row(free_row(jsu_pkg::ChBackslash, 1'b0));
        add_row(free_row(jsu_pkg::ChB, 1'b0));
        // \u0022 comes back as backslash, quote
        add_row(free_row(jsu_pkg::ChBackslash, 1'b0));
        add_row(free_row(jsu_pkg::ChU, 1'b0));
        add_row(free_row(Ch0, 1'b0));
        add_row(free_row(Ch0, 1'b0));
        add_row(free_row(8'h32, 1'b0));
        add_row(free_row(8'h32, 1'b1));
        // bad letter mid string, then the rest up to last is dropped
        add_row(free_row(jsu_pkg::ChBackslash, 1'b0));
        add_row(fixed_row(8'h71, 1'b0, 8'h00, jsu_pkg::ST_BAD_LETTER, 1'b1));
        add_row(free_row(ChUpA, 1'b0));
        add_row(free_row(8'h37, 1'b1));
        // u on the last byte
        add_row(free_row(jsu_pkg::ChBackslash, 1'b0));
        add_row(fixed_row(jsu_pkg::ChU, 1'b1, 8'h00, jsu_pkg::ST_TRUNCATED, 1'b1));
        // backslash on the last byte
        add_row(fixed_row(jsu_pkg::ChBackslash, 1'b1, 8'h00, jsu_pkg::ST_TRUNCATED, 1'b1));
        // invalid digit that is also last: the bad digit wins
        add_row(free_row(jsu_pkg::ChBackslash, 1'b0));
        add_row(free_row(jsu_pkg::ChU, 1'b0));
        add_row(fixed_row(8'h67, 1'b1, 8'h00, jsu_pkg::ST_BAD_HEX, 1'b1));
        // valid digit on the last byte before the fourth
        add_row(free_row(jsu_pkg::ChBackslash, 1'b0));
        add_row(free_row(jsu_pkg::ChU, 1'b0));
        add_row(fixed_row(ChUpF, 1'b1, 8'h00, jsu_pkg::ST_TRUNCATED, 1'b1));
        // error on a last byte drops nothing after it
        add_row(free_row(8'h78, 1'b1));
        foreach (script[i])
            send_word(script[i].b, script[i].last, script[i].typed, script[i].want);

        // random strings across mode settings, last phase with no idling
        random_phase(MODE_RAW);
        random_phase(jsu_pkg::MODE_UTF8);
        random_phase(MODE_RAW);
        calm = 1;
        random_phase(jsu_pkg::MODE_UTF8);

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (owed.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fails == 0) begin
            $display("json_string_unescaper_core: match");
        end else begin
            $display("json_string_unescaper_core: mismatch");
        end
        $finish;
    end

endmodule

[json_string_unescaper_core.f]
design/jsu_pkg.sv
design/jsu_front.sv
design/jsu_queue.sv
design/jsu_back.sv
design/json_string_unescaper_core.sv
design/jsu_checker.sv
bench/json_string_unescaper_core_test.sv
